### hdl/sawc_pkg.sv
// Package with constants, codes and types used by the cache top level.
package sawc_pkg;
  localparam int MAX_LINES      = 256;
  localparam int MAX_LINE_WORDS = 16;
  localparam int MEM_WORDS      = 65536;

  localparam logic [1:0] ACT_READ    = 2'd0;
  localparam logic [1:0] ACT_WRITE   = 2'd1;
  localparam logic [1:0] ACT_PRELOAD = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  localparam logic [2:0] KIND_RD   = 3'd0;
  localparam logic [2:0] KIND_WR   = 3'd1;
  localparam logic [2:0] KIND_FILL = 3'd2;
  localparam logic [2:0] KIND_WB   = 3'd3;
  localparam logic [2:0] KIND_DISC = 3'd4;

  localparam logic [1:0] CFG_LINE = 2'd0;
  localparam logic [1:0] CFG_SETS = 2'd1;
  localparam logic [1:0] CFG_WAYS = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] start_address;
    logic [4:0]  word_count;
    logic [31:0] read_data;
    logic        last;
  } beat_t;
endpackage

### hdl/set_assoc_writeback_cache.sv
// Top level: set-associative write-back cache with LRU and backing memory.
// Usage: input beats carry action, address and write_data on in_valid and
// are taken when in_stall is low. Each read or write yields one to three
// output beats on out_valid: an optional eviction (write-back or discard),
// a fill, then the access itself with last set. Preloads and unused
// actions give no beat. One access is handled at a time.
// On each read or write, the set's tags and ages are walked one way per
// cycle through the state memory port, then the ages are rewritten one way
// per cycle. A miss fills the line from main memory word by word, after a
// dirty victim has been written back word by word; a clean victim is only
// reported. A preload is written to main memory in the idle state, so
// preloads can follow back to back. Reset clears control state, then runs
// a clearing pass over every line state entry; configuration writes start
// the same pass again. No item is accepted during the pass. When the
// receiver stalls, the output beat holds in its register and the walk
// waits; no beat is lost.
module set_assoc_writeback_cache #(
  parameter int MAX_LINES      = sawc_pkg::MAX_LINES,
  parameter int MAX_LINE_WORDS = sawc_pkg::MAX_LINE_WORDS,
  parameter int MEM_WORDS      = sawc_pkg::MEM_WORDS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [15:0]        in_address,
  input  logic signed [31:0] in_write_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_kind,
  output logic [15:0]        out_start_address,
  output logic [4:0]         out_word_count,
  output logic signed [31:0] out_read_data,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data
);
  localparam int LW  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int WW  = (MAX_LINE_WORDS > 1) ? $clog2(MAX_LINE_WORDS) : 1;
  localparam int MW  = $clog2(MEM_WORDS);
  localparam int DW  = LW + WW;
  localparam int CW  = LW + 1;
  localparam int LL2 = $clog2(MAX_LINE_WORDS);
  localparam int SL2 = $clog2(MAX_LINES);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_DEC  = 4'd3;
  localparam logic [3:0] S_EVRD = 4'd4;
  localparam logic [3:0] S_EVWR = 4'd5;
  localparam logic [3:0] S_EVO  = 4'd6;
  localparam logic [3:0] S_FLRD = 4'd7;
  localparam logic [3:0] S_FLWR = 4'd8;
  localparam logic [3:0] S_FLO  = 4'd9;
  localparam logic [3:0] S_AGE  = 4'd10;
  localparam logic [3:0] S_ACC  = 4'd11;
  localparam logic [3:0] S_ACO  = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic [2:0] lg_cfg_r;
  logic [3:0] sg_cfg_r;
  logic [8:0] wy_cfg_r;

  logic [2:0] lg;
  logic [3:0] sg;
  logic [8:0] wy, cap;
  always_comb begin
    lg = (lg_cfg_r > 3'(LL2)) ? 3'(LL2) : lg_cfg_r;
    sg = (sg_cfg_r > 4'(SL2)) ? 4'(SL2) : sg_cfg_r;
    cap = 9'(MAX_LINES >> sg);
    if (cap == 9'd0) cap = 9'd1;
    wy = (wy_cfg_r == 9'd0) ? 9'd1 : wy_cfg_r;
    if (wy > cap) wy = cap;
  end

  logic [1:0]  act_r;
  logic [15:0] addr_r;
  logic [31:0] wd_r;
  logic [LW-1:0] base_r, idx_r, way_r;
  logic [CW-1:0] cnt_r;
  logic        hit_r, inv_r;
  logic [LW-1:0] hitway_r, invway_r, lruway_r;
  logic [7:0]  best_r, wage_r;
  logic [15:0] victag_r;
  logic        vicdirty_r;
  sawc_pkg::beat_t beat_r;
  logic        ovalid_r;

  logic [15:0] tag_a;
  logic [LW-1:0] set_a, base_a;
  logic [4:0]  words;
  assign words = 5'd1 << lg;
  assign tag_a = addr_r >> (lg + sg);
  assign set_a = LW'((addr_r >> lg) & ((17'd1 << sg) - 17'd1));
  assign base_a = LW'(17'(set_a) * 17'(wy));

  // Line state memory: valid, dirty, tag, age.
  logic          st_we;
  logic [LW-1:0] st_wa, st_ra;
  logic [25:0]   st_wd, st_rd;
  sawc_mem #(.DEPTH(MAX_LINES), .WIDTH(26)) u_state (
    .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));
  logic        rd_v, rd_d;
  logic [15:0] rd_tag;
  logic [7:0]  rd_age;
  assign {rd_v, rd_d, rd_tag, rd_age} = st_rd;

  logic          ld_we;
  logic [DW-1:0] ld_wa, ld_ra;
  logic [31:0]   ld_wd, ld_rd;
  sawc_mem #(.DEPTH(MAX_LINES * MAX_LINE_WORDS), .WIDTH(32)) u_line (
    .clk(clk), .we(ld_we), .waddr(ld_wa), .wdata(ld_wd), .raddr(ld_ra), .rdata(ld_rd));

  logic          mm_we;
  logic [MW-1:0] mm_wa, mm_ra;
  logic [31:0]   mm_wd, mm_rd;
  sawc_mem #(.DEPTH(MEM_WORDS), .WIDTH(32)) u_main (
    .clk(clk), .we(mm_we), .waddr(mm_wa), .wdata(mm_wd), .raddr(mm_ra), .rdata(mm_rd));

  logic [CW-1:0] cnt_nxt;
  logic [LW-1:0] idx_nxt;
  logic [15:0]   vfirst, ffirst;
  logic [WW-1:0] widx;
  assign vfirst = 16'((32'(victag_r) << (sg + lg)) | (32'(set_a) << lg));
  assign ffirst = addr_r & ~16'(words - 5'd1);
  assign widx = WW'(cnt_r);

  logic [15:0] lin_off;
  assign lin_off = addr_r & 16'(words - 5'd1);

  logic accept_in, out_fire;
  assign accept_in = in_valid && !in_stall;
  assign out_fire = ovalid_r && !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    st_we = 1'b0; st_wa = idx_r; st_wd = '0; st_ra = idx_r;
    ld_we = 1'b0; ld_wa = {way_r, widx}; ld_wd = mm_rd; ld_ra = {way_r, widx};
    mm_we = 1'b0; mm_wa = MW'(vfirst + 16'(cnt_r)); mm_wd = ld_rd;
    mm_ra = MW'(ffirst + 16'(cnt_r));
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    unique case (state_r)
      S_CLR: begin
        st_we = 1'b1; st_wa = idx_r; st_wd = {2'b00, 16'd0, 8'(wy - 9'd1)};
        idx_nxt = idx_r + LW'(1);
        if (idx_r == LW'(MAX_LINES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept_in && in_action == sawc_pkg::ACT_PRELOAD) begin
          mm_we = 1'b1; mm_wa = MW'(in_address); mm_wd = in_write_data;
        end else if (accept_in && in_action != sawc_pkg::ACT_NONE) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_r == CW'(0)) begin
          st_ra = base_a;
          idx_nxt = base_a;
        end else begin
          st_ra = LW'(32'(idx_r) + 1);
          idx_nxt = idx_r + LW'(1);
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(wy)) begin
          state_nxt = S_DEC;
          cnt_nxt = '0;
        end
      end
      S_DEC: begin
        cnt_nxt = '0;
        if (hit_r) state_nxt = S_AGE;
        else if (inv_r) state_nxt = S_FLRD;
        else if (vicdirty_r) state_nxt = S_EVRD;
        else state_nxt = S_EVO;
        st_ra = base_r;
        idx_nxt = base_r;
      end
      S_EVRD: begin
        state_nxt = S_EVWR;
      end
      S_EVWR: begin
        mm_we = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
        ld_ra = {way_r, WW'(cnt_r + CW'(1))};
        if (cnt_r == CW'(words - 5'd1)) begin
          state_nxt = S_EVO;
          cnt_nxt = '0;
        end
      end
      S_EVO: begin
        if (!ovalid_r) state_nxt = S_FLRD;
      end
      S_FLRD: begin
        state_nxt = S_FLWR;
      end
      S_FLWR: begin
        ld_we = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
        mm_ra = MW'(ffirst + 16'(cnt_r) + 16'd1);
        if (cnt_r == CW'(words - 5'd1)) begin
          state_nxt = S_FLO;
          cnt_nxt = '0;
        end
      end
      S_FLO: begin
        if (!ovalid_r) begin
          state_nxt = S_AGE;
        end
        st_ra = base_r;
        idx_nxt = base_r;
      end
      S_AGE: begin
        // Ages stream out of the state memory, one way a cycle.
        st_ra = (cnt_r == CW'(0)) ? idx_r : LW'(32'(idx_r) + 1);
        if (cnt_r != CW'(0)) begin
          st_we = 1'b1;
          st_wa = idx_r;
          if (idx_r == way_r) begin
            st_wd = {1'b1, (act_r == sawc_pkg::ACT_WRITE) ? 1'b1 :
                     (hit_r ? rd_d : 1'b0), hit_r ? rd_tag : tag_a, 8'd0};
          end else begin
            st_wd = {rd_v, rd_d, rd_tag, (rd_age < wage_r) ? rd_age + 8'd1 : rd_age};
          end
          idx_nxt = idx_r + LW'(1);
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(wy)) begin
          state_nxt = S_ACC;
          cnt_nxt = '0;
        end
      end
      S_ACC: begin
        ld_ra = {way_r, WW'(lin_off)};
        if (act_r == sawc_pkg::ACT_WRITE) begin
          ld_we = 1'b1; ld_wa = {way_r, WW'(lin_off)}; ld_wd = wd_r;
        end
        state_nxt = S_ACO;
      end
      S_ACO: begin
        if (!ovalid_r) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_r) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_we) begin
      state_nxt = S_CLR;
      idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      idx_r    <= '0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
      lg_cfg_r <= 3'd0;
      sg_cfg_r <= 4'd0;
      wy_cfg_r <= 9'd1;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          sawc_pkg::CFG_LINE: lg_cfg_r <= cfg_data[2:0];
          sawc_pkg::CFG_SETS: sg_cfg_r <= cfg_data[3:0];
          sawc_pkg::CFG_WAYS: wy_cfg_r <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (accept_in) begin
            act_r  <= in_action;
            addr_r <= in_address;
            wd_r   <= in_write_data;
          end
        end
        S_SCAN: begin
          if (cnt_r == CW'(0)) begin
            base_r <= base_a;
            hit_r  <= 1'b0; inv_r <= 1'b0; best_r <= 8'd0;
            lruway_r <= base_a;
          end else begin
            if (rd_v && rd_tag == tag_a) begin
              hit_r <= 1'b1; hitway_r <= idx_r;
            end
            if (!rd_v && !inv_r) begin
              inv_r <= 1'b1; invway_r <= idx_r;
            end
            if (rd_age >= best_r) begin
              best_r <= rd_age; lruway_r <= idx_r;
            end
          end
        end
        S_DEC: begin
          if (hit_r) way_r <= hitway_r;
          else if (inv_r) way_r <= invway_r;
          else way_r <= lruway_r;
        end
        default: ;
      endcase
      if (state_r == S_SCAN && cnt_r != CW'(0) && rd_age >= best_r) begin
        victag_r <= rd_tag; vicdirty_r <= rd_d;
      end
      if (state_r == S_SCAN && cnt_r != CW'(0)) begin
        if (rd_v && rd_tag == tag_a) wage_r <= rd_age;
        else if (!rd_v && !inv_r && !hit_r) wage_r <= rd_age;
      end
      if (state_r == S_DEC && !hit_r && !inv_r) wage_r <= best_r;
      if (state_r == S_DEC && !ovalid_r && !hit_r && !inv_r) begin
        ovalid_r <= 1'b1;
        beat_r <= '{kind: vicdirty_r ? sawc_pkg::KIND_WB : sawc_pkg::KIND_DISC,
                    start_address: vfirst, word_count: words, read_data: 32'd0, last: 1'b0};
      end else if (state_r == S_FLWR && cnt_r == CW'(words - 5'd1)) begin
        ovalid_r <= 1'b1;
        beat_r <= '{kind: sawc_pkg::KIND_FILL, start_address: ffirst,
                    word_count: words, read_data: 32'd0, last: 1'b0};
      end else if (state_r == S_ACO && !ovalid_r) begin
        ovalid_r <= 1'b1;
        beat_r <= '{kind: (act_r == sawc_pkg::ACT_READ) ? sawc_pkg::KIND_RD
                          : sawc_pkg::KIND_WR,
                    start_address: addr_r, word_count: 5'd1,
                    read_data: (act_r == sawc_pkg::ACT_READ) ? ld_rd : 32'd0,
                    last: 1'b1};
      end else if (out_fire) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = ovalid_r;
  assign out_kind          = beat_r.kind;
  assign out_start_address = beat_r.start_address;
  assign out_word_count    = beat_r.word_count;
  assign out_read_data     = beat_r.read_data;
  assign out_last          = beat_r.last;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("stalled beat dropped");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_last) |-> (state_r == S_OUT || state_r == S_IDLE || state_r == S_ACO))
    else $error("last beat out of sequence");
endmodule

### hdl/sawc_mem.sv
// Synchronous memory with one write port and one registered read port.
module sawc_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
